FILE: hw/rtl/mcr_pkg.sv
`default_nettype none

package mcr_pkg;

  // default coordinate width of the center inputs
  localparam int unsigned COORD_BITS_DEFAULT = 11;

  // step records held between the front and the back
  localparam int unsigned QUEUE_DEPTH = 2;

  // input operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // eight mirrored pixels per step
  localparam int unsigned PHASE_BITS = 3;
  localparam logic [PHASE_BITS-1:0] LAST_PHASE = 3'd7;

endpackage

`default_nettype wire

FILE: hw/rtl/mcr_front.sv
`default_nettype none

module mcr_front import mcr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic                         op_i,
  input  wire logic signed [COORD_BITS-1:0] center_x_i,
  input  wire logic signed [COORD_BITS-1:0] center_y_i,
  input  wire logic [COORD_BITS-2:0]        radius_i,
  output logic                              emit_o,
  output logic signed [COORD_BITS-1:0]      rec_cx_o,
  output logic signed [COORD_BITS-1:0]      rec_cy_o,
  output logic [COORD_BITS-1:0]             rec_x_o,
  output logic signed [COORD_BITS:0]        rec_y_o,
  output logic                              rec_done_o
);

  localparam int unsigned YW = COORD_BITS + 1;
  localparam int unsigned DW = COORD_BITS + 3;

  logic [COORD_BITS-1:0]        x_q, x_d;
  logic signed [YW-1:0]         y_q, y_d;
  logic signed [DW-1:0]         d_q, d_d;
  logic signed [COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic                         active_q, active_d;

  logic signed [YW-1:0] x_ext, x_new_ext;
  logic signed [YW:0]   diff;
  logic [COORD_BITS-1:0] x_inc;
  logic signed [YW-1:0] y_dec;
  logic [DW-1:0]        d_small, d_large;
  logic                 past_end, can_step;

  assign x_ext    = {1'b0, x_q};
  assign past_end = x_ext > y_q;
  assign can_step = active_q && !past_end;
  assign diff     = {x_ext[YW-1], x_ext} - {y_q[YW-1], y_q};
  // d + 2x + 3 when d < 0, else d + 2(x - y) + 5
  assign d_small  = d_q + {2'b00, x_q, 1'b0} + DW'(3);
  assign d_large  = d_q + {diff, 1'b0} + DW'(5);
  assign x_inc    = x_q + COORD_BITS'(1);
  assign y_dec    = y_q - YW'(1);

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    d_d      = d_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    active_d = active_q;
    emit_o   = 1'b0;
    if (accept_i) begin
      if (op_i == OP_LOAD) begin
        x_d      = '0;
        y_d      = {2'b00, radius_i};
        d_d      = DW'(1) - {4'b0000, radius_i};
        cx_d     = center_x_i;
        cy_d     = center_y_i;
        active_d = 1'b1;
        emit_o   = 1'b1;
      end else if (can_step) begin
        x_d    = x_inc;
        emit_o = 1'b1;
        if (d_q[DW-1]) begin
          d_d = d_small;
        end else begin
          d_d = d_large;
          y_d = y_dec;
        end
      end
    end
  end

  assign x_new_ext  = {1'b0, x_d};
  assign rec_cx_o   = cx_d;
  assign rec_cy_o   = cy_d;
  assign rec_x_o    = x_d;
  assign rec_y_o    = y_d;
  // a load never finishes a circle
  assign rec_done_o = (op_i == OP_ADVANCE) && (x_new_ext > y_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      d_q      <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      active_q <= 1'b0;
    end else begin
      x_q      <= x_d;
      y_q      <= y_d;
      d_q      <= d_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mcr_queue.sv
`default_nettype none

module mcr_queue import mcr_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             rd_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  full_o,
  output logic                  nonempty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [CW-1:0]    cnt_q;
  logic             do_wr, do_rd;

  assign full_o     = cnt_q == CW'(DEPTH);
  assign nonempty_o = cnt_q != '0;
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && nonempty_o;
  assign rdata_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_rd) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mcr_back.sv
`default_nettype none

module mcr_back import mcr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         rec_avail_i,
  input  wire logic signed [COORD_BITS-1:0] rec_cx_i,
  input  wire logic signed [COORD_BITS-1:0] rec_cy_i,
  input  wire logic [COORD_BITS-1:0]        rec_x_i,
  input  wire logic signed [COORD_BITS:0]   rec_y_i,
  input  wire logic                         rec_done_i,
  output logic                              rec_take_o,
  input  wire logic                         pop_i,
  output logic                              empty_o,
  output logic signed [COORD_BITS:0]        pixel_x_o,
  output logic signed [COORD_BITS:0]        pixel_y_o,
  output logic                              last_of_run_o,
  output logic                              circle_done_o
);

  localparam int unsigned YW = COORD_BITS + 1;

  logic                         busy_q;
  logic [PHASE_BITS-1:0]        phase_q;
  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic [COORD_BITS-1:0]        x_q;
  logic signed [YW-1:0]         y_q;
  logic                         done_q;

  logic                         out_valid_q;
  logic signed [YW-1:0]         px_q, py_q;
  logic                         last_q, fin_q;

  logic                 advance, end_of_run;
  logic signed [YW-1:0] a_ext, off_x, off_y, px, py;
  logic                 is_last;

  // output register moves when empty or being popped
  assign advance    = !out_valid_q || pop_i;
  assign is_last    = phase_q == LAST_PHASE;
  assign end_of_run = advance && busy_q && is_last;
  assign rec_take_o = rec_avail_i && (!busy_q || end_of_run);

  // phase bit 2 swaps x and y, bit 0 mirrors x, bit 1 mirrors y
  assign a_ext = {1'b0, x_q};
  assign off_x = phase_q[2] ? y_q : a_ext;
  assign off_y = phase_q[2] ? a_ext : y_q;
  assign px    = phase_q[0] ? {cx_q[COORD_BITS-1], cx_q} - off_x
                            : {cx_q[COORD_BITS-1], cx_q} + off_x;
  assign py    = phase_q[1] ? {cy_q[COORD_BITS-1], cy_q} - off_y
                            : {cy_q[COORD_BITS-1], cy_q} + off_y;

  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      cx_q   <= rec_cx_i;
      cy_q   <= rec_cy_i;
      x_q    <= rec_x_i;
      y_q    <= rec_y_i;
      done_q <= rec_done_i;
    end
    if (advance && busy_q) begin
      px_q   <= px;
      py_q   <= py;
      last_q <= is_last;
      fin_q  <= is_last && done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= busy_q;
      end
      if (rec_take_o) begin
        busy_q  <= 1'b1;
        phase_q <= '0;
      end else if (end_of_run) begin
        busy_q  <= 1'b0;
        phase_q <= '0;
      end else if (advance && busy_q) begin
        phase_q <= phase_q + PHASE_BITS'(1);
      end
    end
  end

  assign empty_o       = !out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign last_of_run_o = last_q;
  assign circle_done_o = fin_q;

endmodule

`default_nettype wire

FILE: hw/rtl/midpoint_circle_rasterizer_top.sv
// Midpoint circle rasterizer.
// Input queue port: push with op_i and the load fields; a request is taken
// when push is high and full is low. op_i = load starts a circle at
// (center_x_i, center_y_i) with radius_i; op_i = advance runs one octant step.
// An advance with no circle loaded, or after x has passed y, yields nothing.
// Output queue port: while empty is low the oldest pixel is on pixel_x_o /
// pixel_y_o; pop takes it. Each load or live advance yields eight pixels,
// the eighth flagged by last_of_run_o, and circle_done_o on the final step.
// Throughput: one pixel per cycle while pop is high and step records wait,
// set by the single pixel output register. The front updates the circle
// state as each request is taken and parks step records in a two-entry
// queue, so requests are taken while pixels of earlier steps drain; full
// rises when that queue is full. When pop stays low the pixel register
// holds, the back stalls, and the queue fills up before full pushes back.
// Reset clears all control state; no circle is loaded and no pixel is shown.
`default_nettype none

module midpoint_circle_rasterizer_top import mcr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         op_i,
  input  wire logic signed [COORD_BITS-1:0] center_x_i,
  input  wire logic signed [COORD_BITS-1:0] center_y_i,
  input  wire logic [COORD_BITS-2:0]        radius_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic signed [COORD_BITS:0]        pixel_x_o,
  output logic signed [COORD_BITS:0]        pixel_y_o,
  output logic                              last_of_run_o,
  output logic                              circle_done_o
);

  localparam int unsigned RW = 4 * COORD_BITS + 2;

  logic                         accept;
  logic                         emit;
  logic signed [COORD_BITS-1:0] f_cx, f_cy, b_cx, b_cy;
  logic [COORD_BITS-1:0]        f_x, b_x;
  logic signed [COORD_BITS:0]   f_y, b_y;
  logic                         f_done, b_done;
  logic [RW-1:0]                q_wdata, q_rdata;
  logic                         q_nonempty, q_take;

  assign accept = push && !full;

  mcr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .emit_o     (emit),
    .rec_cx_o   (f_cx),
    .rec_cy_o   (f_cy),
    .rec_x_o    (f_x),
    .rec_y_o    (f_y),
    .rec_done_o (f_done)
  );

  assign q_wdata = {f_done, f_y, f_x, f_cy, f_cx};

  mcr_queue #(
    .WIDTH(RW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (emit),
    .wdata_i    (q_wdata),
    .rd_i       (q_take),
    .rdata_o    (q_rdata),
    .full_o     (full),
    .nonempty_o (q_nonempty)
  );

  assign {b_done, b_y, b_x, b_cy, b_cx} = q_rdata;

  mcr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_avail_i   (q_nonempty),
    .rec_cx_i      (b_cx),
    .rec_cy_i      (b_cy),
    .rec_x_i       (b_x),
    .rec_y_i       (b_y),
    .rec_done_i    (b_done),
    .rec_take_o    (q_take),
    .pop_i         (pop),
    .empty_o       (empty),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .last_of_run_o (last_of_run_o),
    .circle_done_o (circle_done_o)
  );

endmodule

`default_nettype wire
